FILE: hdl/tuc_pkg.sv
// ----------------------------------------------------------------------------
// tuc_pkg: shared types and constants of the TAI/UTC converter
// Holds the leap-second list, the token that walks the cell row, and the
// elaboration-time helpers that turn a list entry into epoch thresholds.
// ----------------------------------------------------------------------------
package tuc_pkg;

  // Default number of table rows (cells in the row).
  localparam int TABLE_ENTRIES_DEF = 32;

  // Fixed leap-second list, newest first, ending with the end marker.
  localparam int LIST_LEN = 29;

  localparam logic [31:0] END_STAMP  = 32'hFFFF_FFFF;
  localparam logic [7:0]  END_OFFSET = 8'd11;

  localparam longint      SECS_1900_TO_1970 = 64'sd2208988800;
  localparam longint      NS_PER_SEC_S      = 64'sd1000000000;
  localparam logic [63:0] NS_PER_SEC        = 64'd1000000000;

  // Narrow forms used by the offset multiplier.
  localparam int          OFF_W   = 8;
  localparam int          NS_W    = 30;
  localparam int          PROD_W  = OFF_W + NS_W;
  localparam logic [NS_W-1:0] NS_PER_SEC_N = 30'd1000000000;

  localparam logic [31:0] LIST_STAMP [LIST_LEN] = '{
    32'd3692217600, 32'd3644697600, 32'd3550089600, 32'd3439756800, 32'd3345062400,
    32'd3124137600, 32'd3076704000, 32'd3029443200, 32'd2982009600, 32'd2950473600,
    32'd2918937600, 32'd2871676800, 32'd2840140800, 32'd2776982400, 32'd2698012800,
    32'd2634854400, 32'd2603318400, 32'd2571782400, 32'd2524521600, 32'd2492985600,
    32'd2461449600, 32'd2429913600, 32'd2398291200, 32'd2366755200, 32'd2335219200,
    32'd2303683200, 32'd2287785600, 32'd2272060800, 32'hFFFF_FFFF
  };

  localparam logic [7:0] LIST_OFF [LIST_LEN] = '{
    8'd37, 8'd36, 8'd35, 8'd34, 8'd33, 8'd32, 8'd31, 8'd30, 8'd29, 8'd28,
    8'd27, 8'd26, 8'd25, 8'd24, 8'd23, 8'd22, 8'd21, 8'd20, 8'd19, 8'd18,
    8'd17, 8'd16, 8'd15, 8'd14, 8'd13, 8'd12, 8'd11, 8'd10, 8'd11
  };

  // Query token handed from cell to cell.
  typedef struct packed {
    logic              utc;       // search on the UTC scale
    logic              later;     // pick the later copy of a repeated second
    logic [63:0]       t;         // time being looked up, in ns
    logic              found;     // offset row already found
    logic              rep;       // hit a repeated UTC second
    logic [OFF_W-1:0]  off;       // chosen offset in seconds
    logic              found_lp;  // leap row already found
    logic [1:0]        kind;      // leap kind of the TAI second
  } token_t;

  // Stamp of a table row; rows past the list or past the table are end markers.
  function automatic logic [31:0] entry_stamp(input int idx, input int entries);
    logic [31:0] val;
    val = END_STAMP;
    if (idx < entries && idx < LIST_LEN) val = LIST_STAMP[idx];
    return val;
  endfunction

  // Offset of a table row, with the same end-marker rule.
  function automatic logic [7:0] entry_off(input int idx, input int entries);
    logic [7:0] val;
    val = END_OFFSET;
    if (idx < entries && idx < LIST_LEN) val = LIST_OFF[idx];
    return val;
  endfunction

  // Start of a row's epoch in ns, on the TAI scale or shifted to the UTC scale.
  function automatic logic [63:0] epoch_ns(input logic [31:0] stamp,
                                           input logic [7:0]  off,
                                           input logic [7:0]  next_off,
                                           input logic        utc_side);
    longint sec;
    sec = $signed({32'd0, stamp}) - SECS_1900_TO_1970 + $signed({56'd0, off});
    if (next_off < off) sec = sec - 64'sd1;
    if (utc_side) sec = sec - $signed({56'd0, off});
    return 64'(sec * NS_PER_SEC_S);
  endfunction

  // Leap kind reported at the exact epoch second, kept to two bits.
  function automatic logic [1:0] leap_code(input logic [7:0] off,
                                           input logic [7:0] next_off);
    logic [7:0] d;
    d = off - next_off;
    return d[1:0];
  endfunction

endpackage

FILE: hdl/tuc_if.sv
// ----------------------------------------------------------------------------
// tuc_if: request and result channels of the TAI/UTC converter
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface tuc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] time_in;
  logic        leap_later;

  modport source (output valid, command, time_in, leap_later, input ready);
  modport sink   (input valid, command, time_in, leap_later, output ready);
endinterface

interface tuc_out_if;
  logic              valid;
  logic              ready;
  logic [63:0]       time_out;
  logic              valid_res;
  logic signed [1:0] leap_kind;
  logic [6:0]        offset_seconds;

  modport source (output valid, time_out, valid_res, leap_kind, offset_seconds,
                  input ready);
  modport sink   (input valid, time_out, valid_res, leap_kind, offset_seconds,
                  output ready);
endinterface

FILE: hdl/tuc_cell.sv
// ----------------------------------------------------------------------------
// tuc_cell: one row of the leap-second table
// Holds one table row as constants, tests the passing token against the
// row's epoch and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module tuc_cell #(
  parameter int INDEX         = 0,
  parameter int TABLE_ENTRIES = tuc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tok_vld_i,
  input  tuc_pkg::token_t tok_i,
  output logic            tok_vld_o,
  output tuc_pkg::token_t tok_o
);

  // This row and the one after it.
  localparam logic [31:0] STAMP      = tuc_pkg::entry_stamp(INDEX, TABLE_ENTRIES);
  localparam logic [7:0]  OFF        = tuc_pkg::entry_off(INDEX, TABLE_ENTRIES);
  localparam logic [31:0] NEXT_STAMP = tuc_pkg::entry_stamp(INDEX + 1, TABLE_ENTRIES);
  localparam logic [7:0]  NEXT_OFF   = tuc_pkg::entry_off(INDEX + 1, TABLE_ENTRIES);

  localparam logic        IS_END   = (STAMP == tuc_pkg::END_STAMP);
  localparam logic        NEXT_END = (NEXT_STAMP == tuc_pkg::END_STAMP);
  localparam logic        POS_LEAP = (NEXT_OFF < OFF);
  localparam logic [1:0]  LEAP_K   = tuc_pkg::leap_code(OFF, NEXT_OFF);
  localparam logic [63:0] TAI_NS   = tuc_pkg::epoch_ns(STAMP, OFF, NEXT_OFF, 1'b0);
  localparam logic [63:0] UTC_NS   = tuc_pkg::epoch_ns(STAMP, OFF, NEXT_OFF, 1'b1);

  logic [63:0]     ref_ns;
  logic [63:0]     diff;
  logic            ge;
  logic            eq;
  tuc_pkg::token_t tok_nxt;
  logic            vld_r;
  tuc_pkg::token_t tok_r;

  // Compare the token time with this row's epoch start on its scale.
  always_comb begin
    ref_ns = tok_i.utc ? UTC_NS : TAI_NS;
    ge     = IS_END | (tok_i.t >= ref_ns);
    diff   = tok_i.t - ref_ns;
    eq     = ~IS_END & ge & (diff < tuc_pkg::NS_PER_SEC);
  end

  // The first matching row settles the offset, and on the TAI scale the leap kind.
  always_comb begin
    tok_nxt = tok_i;
    if (!tok_i.found && (ge || NEXT_END)) begin
      tok_nxt.found = 1'b1;
      if (tok_i.utc && eq && POS_LEAP) begin
        tok_nxt.rep = 1'b1;
        tok_nxt.off = tok_i.later ? OFF : NEXT_OFF;
      end else begin
        tok_nxt.rep = 1'b0;
        tok_nxt.off = OFF;
      end
    end
    if (!tok_i.utc && !tok_i.found_lp && ge) begin
      tok_nxt.found_lp = 1'b1;
      tok_nxt.kind     = eq ? LEAP_K : 2'b00;
    end
  end

  // Token valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= tok_vld_i;
    end
  end

  // Token payload.
  always_ff @(posedge clk) begin
    if (tok_vld_i) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_vld_o = vld_r;
  assign tok_o     = tok_r;

endmodule

FILE: hdl/tuc_ctrl.sv
// ----------------------------------------------------------------------------
// tuc_ctrl: request sequencer of the TAI/UTC converter
// Launches tokens into the cell row, applies the found offset, runs the
// round-trip check for UTC input and holds the result register.
// ----------------------------------------------------------------------------
module tuc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  tuc_in_if.sink          in_chan,
  tuc_out_if.source       out_chan,
  output logic            launch_vld_o,
  output tuc_pkg::token_t launch_o,
  input  logic            ret_vld_i,
  input  tuc_pkg::token_t ret_i
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_WALK  = 6'b000010,
    ST_ADD   = 6'b000100,
    ST_WALK2 = 6'b001000,
    ST_CMP   = 6'b010000,
    ST_HOLD  = 6'b100000
  } state_t;

  state_t                         state_r;
  state_t                         state_nxt;
  logic                           hold_load;
  logic [63:0]                    t_r;
  logic                           cmd_r;
  logic [tuc_pkg::OFF_W-1:0]      o_r;
  logic [1:0]                     kind_r;
  logic                           rep_r;
  logic [tuc_pkg::PROD_W-1:0]     prod_r;
  logic [tuc_pkg::PROD_W-1:0]     mul;
  logic [63:0]                    prod_ext;
  logic [63:0]                    sum;
  logic [63:0]                    dif;
  logic [63:0]                    res_r;
  logic                           ok_r;
  logic                           out_vld_r;
  logic [63:0]                    out_time_r;
  logic                           out_ok_r;
  logic [1:0]                     out_kind_r;
  logic [6:0]                     out_offs_r;

  // Offset in seconds times one second in ns, from the returning token.
  assign mul = {{tuc_pkg::NS_W{1'b0}}, ret_i.off}
             * {{tuc_pkg::OFF_W{1'b0}}, tuc_pkg::NS_PER_SEC_N};
  assign prod_ext = {{(64 - tuc_pkg::PROD_W){1'b0}}, prod_r};
  assign sum      = t_r + prod_ext;
  assign dif      = t_r - prod_ext;

  // New requests enter the row from idle; the round-trip check enters after the add.
  always_comb begin
    launch_vld_o      = (state_r == ST_IDLE && in_chan.valid)
                      || (state_r == ST_ADD && cmd_r && !rep_r);
    launch_o          = '0;
    launch_o.utc      = (state_r == ST_IDLE) ? in_chan.command : 1'b0;
    launch_o.later    = in_chan.leap_later;
    launch_o.t        = (state_r == ST_IDLE) ? in_chan.time_in : sum;
  end

  assign in_chan.ready = (state_r == ST_IDLE);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    hold_load = 1'b0;
    unique case (state_r)
      ST_IDLE:  if (in_chan.valid) state_nxt = ST_WALK;
      ST_WALK:  if (ret_vld_i) state_nxt = ST_ADD;
      ST_ADD: begin
        if (cmd_r && !rep_r) state_nxt = ST_WALK2;
        else                 state_nxt = ST_HOLD;
      end
      ST_WALK2: if (ret_vld_i) state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_HOLD;
      ST_HOLD: begin
        if (!out_vld_r || out_chan.ready) begin
          state_nxt = ST_IDLE;
          hold_load = 1'b1;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers of the request in progress.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          t_r   <= in_chan.time_in;
          cmd_r <= in_chan.command;
        end
      end
      ST_WALK: begin
        if (ret_vld_i) begin
          o_r    <= ret_i.off;
          kind_r <= ret_i.kind;
          rep_r  <= ret_i.rep;
          prod_r <= mul;
        end
      end
      ST_ADD: begin
        ok_r  <= 1'b1;
        res_r <= cmd_r ? sum : dif;
      end
      ST_WALK2: begin
        if (ret_vld_i) prod_r <= mul;
      end
      ST_CMP: begin
        // The candidate TAI time must map back to the same UTC time.
        ok_r <= ((res_r - prod_ext) == t_r);
      end
      default: ;
    endcase
  end

  // Result register; a failed UTC lookup reports zero time and offset.
  always_ff @(posedge clk) begin
    if (hold_load) begin
      out_time_r <= ok_r ? res_r : 64'd0;
      out_ok_r   <= ok_r;
      out_kind_r <= kind_r;
      out_offs_r <= ok_r ? o_r[6:0] : 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (hold_load) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_chan.valid          = out_vld_r;
  assign out_chan.time_out       = out_time_r;
  assign out_chan.valid_res      = out_ok_r;
  assign out_chan.leap_kind      = $signed(out_kind_r);
  assign out_chan.offset_seconds = out_offs_r;

endmodule

FILE: hdl/tai_utc_leap_second_convert_unit.sv
// ----------------------------------------------------------------------------
// tai_utc_leap_second_convert_unit: TAI/UTC timestamp converter
// Converts 64-bit ns timestamps between TAI and UTC with a built-in
// leap-second table held in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries command (0 = TAI to UTC, 1 = UTC to TAI), time_in and
//   leap_later. out_chan returns time_out, valid_res, leap_kind and
//   offset_seconds, one result per request, in order.
//   A request token walks the row of TABLE_ENTRIES cells, one cell per
//   cycle, and the first matching row sets the offset.
//   TAI to UTC, and UTC input that lands in a repeated second: one walk of
//   the row, then the add, then the result register.
//   Other UTC input walks the row a second time to check the round trip
//   before the result register is loaded.
//   One request is in work at a time; a new one is taken only once the
//   last has moved on into the result register.
//   The result register frees the input side: a request is taken while the
//   previous result still waits. If out_chan stalls, the finished result
//   waits inside and in_chan stays not ready until it moves on.
//   Reset empties the row and the result register; the table rows are
//   constants and need no fill after reset.
// ----------------------------------------------------------------------------
module tai_utc_leap_second_convert_unit #(
  parameter int TABLE_ENTRIES = tuc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tuc_in_if.sink    in_chan,
  tuc_out_if.source out_chan
);

  logic [TABLE_ENTRIES:0] tok_vld;
  tuc_pkg::token_t        tok [TABLE_ENTRIES+1];

  // Sequencer and result register.
  tuc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .out_chan     (out_chan),
    .launch_vld_o (tok_vld[0]),
    .launch_o     (tok[0]),
    .ret_vld_i    (tok_vld[TABLE_ENTRIES]),
    .ret_i        (tok[TABLE_ENTRIES])
  );

  // Row of table cells, newest entry first.
  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    tuc_cell #(
      .INDEX         (k),
      .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_vld_i (tok_vld[k]),
      .tok_i     (tok[k]),
      .tok_vld_o (tok_vld[k+1]),
      .tok_o     (tok[k+1])
    );
  end

endmodule

FILE: hdl/tuc_checker.sv
// ----------------------------------------------------------------------------
// tuc_checker: port-level checks of the TAI/UTC converter
// Watches the channels of the top level and flags results that the
// conversion can never give.
// ----------------------------------------------------------------------------
module tuc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [63:0]       time_out,
  input logic              valid_res,
  input logic signed [1:0] leap_kind,
  input logic [6:0]        offset_seconds
);

  // Only one request is in work: ready drops right after a transfer.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while a request was in work");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(time_out)
      && $stable(valid_res) && $stable(leap_kind) && $stable(offset_seconds))
    else $error("result changed while stalled");

  // An invalid result, such as a skipped UTC second, reports zero time and zero offset.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !valid_res |-> time_out == 64'd0 && offset_seconds == 7'd0)
    else $error("invalid result carries nonzero fields");

  // Leap kind comes only with a good conversion.
  a_leap_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && leap_kind != 2'sb00 |-> valid_res)
    else $error("leap kind reported on an invalid result");

  // Applied offsets come from the table and stay within its range.
  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && valid_res |-> offset_seconds >= 7'd10 && offset_seconds <= 7'd37)
    else $error("offset outside the table range");

endmodule

bind tai_utc_leap_second_convert_unit tuc_checker u_tuc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .time_out       (out_chan.time_out),
  .valid_res      (out_chan.valid_res),
  .leap_kind      (out_chan.leap_kind),
  .offset_seconds (out_chan.offset_seconds)
);

FILE: tb/sv/tb_tai_utc_leap_second_convert_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tai_utc_leap_second_convert_unit: self-checking bench of the converter
// A short table of directed requests is sent first: the field extremes, both
// directions, leap seconds, repeated and wrapped seconds. Random requests
// follow in four phases of sender idling and receiver stalling. An in-bench
// leap-second predictor works out every result, and each result transfer is
// checked field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_tai_utc_leap_second_convert_unit;

  // Conversion direction and leap kind codes.
  typedef enum logic {CONV_TO_UTC = 1'b0, CONV_TO_TAI = 1'b1} conv_cmd_t;

  localparam logic [1:0] LEAP_NONE   = 2'b00;
  localparam logic [1:0] LEAP_REMOVE = 2'b11;

  typedef struct packed {
    logic [63:0] time_out;
    logic        valid_res;
    logic [1:0]  leap_kind;
    logic [6:0]  offset_seconds;
  } conv_res_t;

  typedef struct packed {
    conv_cmd_t   cmd;
    logic [63:0] t;
    logic        later;
    logic        typed;   // the expected result is written in the row
    conv_res_t   want;
  } dir_row_t;

  localparam int          TABLE_ROWS   = tuc_pkg::TABLE_ENTRIES_DEF;
  localparam int          LEAP_ROWS    = 28;   // real entries; the rest are end markers
  localparam longint      EPOCH_SHIFT  = 64'sd2208988800;
  localparam logic [63:0] NS           = 64'd1000000000;
  localparam longint      CYCLE_LIMIT  = 1000000;
  localparam int          RAND_PER_PHASE = 263;
  localparam conv_res_t   NO_RES       = '0;

  // Leap-second entries, newest first, in seconds since 1900.
  localparam longint LEAP_STAMPS [LEAP_ROWS] = '{
    64'sd3692217600, 64'sd3644697600, 64'sd3550089600, 64'sd3439756800,
    64'sd3345062400, 64'sd3124137600, 64'sd3076704000, 64'sd3029443200,
    64'sd2982009600, 64'sd2950473600, 64'sd2918937600, 64'sd2871676800,
    64'sd2840140800, 64'sd2776982400, 64'sd2698012800, 64'sd2634854400,
    64'sd2603318400, 64'sd2571782400, 64'sd2524521600, 64'sd2492985600,
    64'sd2461449600, 64'sd2429913600, 64'sd2398291200, 64'sd2366755200,
    64'sd2335219200, 64'sd2303683200, 64'sd2287785600, 64'sd2272060800
  };

  // Idling per phase, in percent of cycles.
  localparam int PHASE_IDLE  [4] = '{0, 83, 0, 38};
  localparam int PHASE_STALL [4] = '{0, 0, 83, 38};

  localparam int DIR_ROWS = 19;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // Zero TAI: before 1972, the subtraction wraps.
    '{CONV_TO_UTC, 64'd0, 1'b0, 1'b1,
      '{64'd0 - 64'd10 * NS, 1'b1, LEAP_NONE, 7'd10}},
    // Largest TAI: newest offset.
    '{CONV_TO_UTC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
      '{64'hFFFF_FFFF_FFFF_FFFF - 64'd37 * NS, 1'b1, LEAP_NONE, 7'd37}},
    // Zero UTC.
    '{CONV_TO_TAI, 64'd0, 1'b0, 1'b1, '{64'd10 * NS, 1'b1, LEAP_NONE, 7'd10}},
    // Largest UTC: the sum wraps and the round trip fails.
    '{CONV_TO_TAI, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
      '{64'd0, 1'b0, LEAP_NONE, 7'd0}},
    // Epoch of the oldest entry reports a removed second against the end marker.
    '{CONV_TO_UTC, 64'd63072010 * NS, 1'b0, 1'b1,
      '{64'd63072000 * NS, 1'b1, LEAP_REMOVE, 7'd10}},
    // Around the newest inserted leap second.
    '{CONV_TO_UTC, 64'd1483228836 * NS + 64'd5, 1'b0, 1'b0, NO_RES},
    '{CONV_TO_UTC, 64'd1483228835 * NS + 64'd999999999, 1'b0, 1'b0, NO_RES},
    '{CONV_TO_UTC, 64'd1483228837 * NS, 1'b1, 1'b0, NO_RES},
    '{CONV_TO_TAI, 64'd1483228799 * NS + 64'd999999999, 1'b0, 1'b0, NO_RES},
    '{CONV_TO_TAI, 64'd1483228799 * NS + 64'd999999999, 1'b1, 1'b0, NO_RES},
    '{CONV_TO_TAI, 64'd1483228800 * NS, 1'b1, 1'b0, NO_RES},
    // Around the oldest inserted leap second.
    '{CONV_TO_TAI, 64'd78796799 * NS, 1'b1, 1'b0, NO_RES},
    '{CONV_TO_TAI, 64'd78796799 * NS, 1'b0, 1'b0, NO_RES},
    '{CONV_TO_UTC, 64'd78796810 * NS, 1'b0, 1'b0, NO_RES},
    '{CONV_TO_TAI, 64'd63071999 * NS + 64'd1, 1'b0, 1'b0, NO_RES},
    // Wrap near the top, small TAI, the sign bit, an ordinary later flag.
    '{CONV_TO_TAI, 64'hFFFF_FFF0_0000_0000, 1'b0, 1'b0, NO_RES},
    '{CONV_TO_UTC, 64'd10 * NS - 64'd1, 1'b1, 1'b0, NO_RES},
    '{CONV_TO_UTC, 64'h8000_0000_0000_0000, 1'b0, 1'b0, NO_RES},
    '{CONV_TO_TAI, 64'd1600000000 * NS + 64'd123, 1'b1, 1'b0, NO_RES}
  };

  logic clk;
  logic rst_n;

  tuc_in_if  in_chan();
  tuc_out_if out_chan();

  tai_utc_leap_second_convert_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  conv_res_t pending_conversions[$];
  conv_res_t oldest_conversion;
  int        mismatch_count;
  int        sender_idle;
  int        receiver_stall;
  longint    cycle_count;

  // ---------------------------------------------------------------------------
  // Leap-second predictor
  // ---------------------------------------------------------------------------

  // Offset of a row; rows past the list read as the end marker.
  function automatic longint row_offset(int idx);
    if (idx < LEAP_ROWS) return 64'sd37 - longint'(idx);
    return 64'sd11;
  endfunction

  // First TAI second of a row, one earlier for an inserted second; -1 at the end.
  function automatic longint row_start(int idx);
    longint sec;
    if (idx >= LEAP_ROWS) return -64'sd1;
    sec = LEAP_STAMPS[idx] - EPOCH_SHIFT + row_offset(idx);
    if (row_offset(idx + 1) < row_offset(idx)) sec = sec - 64'sd1;
    return sec;
  endfunction

  function automatic longint tai_offset(logic [63:0] tai);
    longint sec;
    int     idx;
    sec = longint'(tai / NS);
    for (idx = 0; idx <= TABLE_ROWS; idx++) begin
      if (sec >= row_start(idx) || row_start(idx + 1) == -64'sd1)
        return row_offset(idx);
    end
    return row_offset(idx);
  endfunction

  function automatic longint tai_leap_kind(logic [63:0] tai);
    longint sec;
    int     idx;
    sec = longint'(tai / NS);
    for (idx = 0; idx <= TABLE_ROWS; idx++) begin
      if (sec >= row_start(idx)) begin
        if (sec == row_start(idx)) return row_offset(idx) - row_offset(idx + 1);
        return 64'sd0;
      end
    end
    return 64'sd0;
  endfunction

  function automatic conv_res_t convert_time(conv_cmd_t cmd, logic [63:0] t, logic later);
    conv_res_t   res;
    longint      sec;
    longint      tai_sec;
    longint      off;
    logic [63:0] tai;
    logic        ok;
    int          idx;
    res = '0;
    ok  = 1'b1;
    off = 0;
    if (cmd == CONV_TO_UTC) begin
      off                = tai_offset(t);
      res.time_out       = t - 64'(off) * NS;
      res.valid_res      = 1'b1;
      res.leap_kind      = 2'(tai_leap_kind(t));
      res.offset_seconds = 7'(off);
    end else begin
      sec = longint'(t / NS);
      for (idx = 0; idx <= TABLE_ROWS; idx++) begin
        tai_sec = sec + row_offset(idx);
        if (tai_sec >= row_start(idx) || row_start(idx + 1) == -64'sd1) begin
          if (tai_sec == row_start(idx) && row_offset(idx + 1) < row_offset(idx)) begin
            // Repeated UTC second: the flag picks one of its two TAI copies.
            off = later ? row_offset(idx) : row_offset(idx + 1);
          end else begin
            // A skipped second shows up as a failed round trip.
            off = row_offset(idx);
            tai = t + 64'(off) * NS;
            ok  = ((tai - 64'(tai_offset(tai)) * NS) == t);
          end
          break;
        end
      end
      res.valid_res = ok;
      if (ok) begin
        res.time_out       = t + 64'(off) * NS;
        res.offset_seconds = 7'(off);
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Sends one request after a random gap and records its expected result.
  task automatic send_request(input conv_cmd_t cmd, input logic [63:0] t,
                              input logic later, input conv_res_t want);
    while ($urandom_range(99) < sender_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.command    <= cmd;
    in_chan.time_in    <= t;
    in_chan.leap_later <= later;
    do @(posedge clk); while (!in_chan.ready);
    pending_conversions.push_back(want);
  endtask

  // Drains every outstanding result with the request side quiet.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_conversions.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t: %s expected %h, got %h", $time, field, want, got);
    mismatch_count++;
  endtask

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= receiver_stall);
  end

  // Each result transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_conversions.size() == 0) begin
        report_mismatch("unexpected result, time_out", 64'd0, out_chan.time_out);
      end else begin
        oldest_conversion = pending_conversions.pop_front();
        if (out_chan.time_out !== oldest_conversion.time_out)
          report_mismatch("time_out", oldest_conversion.time_out, out_chan.time_out);
        if (out_chan.valid_res !== oldest_conversion.valid_res)
          report_mismatch("valid_res", 64'(oldest_conversion.valid_res),
                          64'(out_chan.valid_res));
        if (out_chan.leap_kind !== oldest_conversion.leap_kind)
          report_mismatch("leap_kind", 64'(oldest_conversion.leap_kind),
                          64'(unsigned'(out_chan.leap_kind)));
        if (out_chan.offset_seconds !== oldest_conversion.offset_seconds)
          report_mismatch("offset_seconds", 64'(oldest_conversion.offset_seconds),
                          64'(out_chan.offset_seconds));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_tai_utc_leap_second_convert_unit: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    conv_cmd_t   cmd;
    logic [63:0] t;
    logic [63:0] frac;
    logic        later;
    longint      sec;
    int          pick;
    int          idx;
    int          phase;
    int          n;

    mismatch_count      = 0;
    sender_idle         = 0;
    receiver_stall      = 0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.command    <= CONV_TO_UTC;
    in_chan.time_in    <= '0;
    in_chan.leap_later <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no idling.
    for (n = 0; n < DIR_ROWS; n++) begin
      send_request(DIR_TABLE[n].cmd, DIR_TABLE[n].t, DIR_TABLE[n].later,
                   DIR_TABLE[n].typed ? DIR_TABLE[n].want
                                      : convert_time(DIR_TABLE[n].cmd, DIR_TABLE[n].t,
                                                     DIR_TABLE[n].later));
    end
    drain_results();

    // Random requests, one idling pattern per phase, drained in between.
    for (phase = 0; phase < 4; phase++) begin
      sender_idle    = PHASE_IDLE[phase];
      receiver_stall = PHASE_STALL[phase];
      for (n = 0; n < RAND_PER_PHASE; n++) begin
        cmd   = conv_cmd_t'($urandom_range(1));
        later = 1'($urandom_range(1));
        case ($urandom_range(9))
          0:       frac = 64'd0;
          1:       frac = NS - 64'd1;
          default: frac = 64'($urandom_range(999999999));
        endcase
        pick = $urandom_range(99);
        if (pick < 45) begin
          // A few seconds around a leap, on the source scale.
          idx = $urandom_range(LEAP_ROWS - 1);
          sec = row_start(idx) + longint'($urandom_range(4)) - 64'sd2;
          if (cmd == CONV_TO_TAI) sec = sec - row_offset(idx);
          t = 64'(sec) * NS + frac;
        end else if (pick < 75) begin
          // Anywhere between 1970 and the late 2030s.
          t = 64'($urandom_range(2100000000)) * NS + frac;
        end else if (pick < 85) begin
          // Just below the top, where the sums wrap.
          t = 64'hFFFF_FFFF_FFFF_FFFF - (64'($urandom_range(60)) * NS + frac);
        end else begin
          t = {$urandom, $urandom};
        end
        send_request(cmd, t, later, convert_time(cmd, t, later));
      end
      drain_results();
    end

    // Catch any stray result before the verdict.
    repeat (2 * TABLE_ROWS + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_tai_utc_leap_second_convert_unit: clean");
    end else begin
      $display("tb_tai_utc_leap_second_convert_unit: errors");
    end
    $finish;
  end

endmodule
